// ----- src/brb_pkg.sv -----
// Package for the beacon range and bearing block.
// Holds widths, pipeline stage positions, register indexes and the CORDIC angle table.
// No dependencies; imported by every module of the block.
`default_nettype none

package brb_pkg;

    localparam int FRAC_BITS   = 4;
    localparam int COORD_W     = 20;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int HEAD_W      = 13;
    localparam int HEAD_SH     = 12;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int REM_W       = 36;
    localparam int ROOT_W      = 17;
    localparam int ALT_W       = 17;
    localparam int RB_W        = 9;
    localparam int CX_W        = 44;
    localparam int ANG_W       = 28;
    localparam int CORDIC_N    = 20;
    localparam int PRESCALE_SH = 20;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SH    = 24;
    localparam int PROD_W      = ROOT_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SH;

    localparam logic [RECIP_W-1:0] RECIP_100 = 18'd167773;
    localparam logic [ROOT_W-1:0]  DIST_LIMIT = 17'd1000;
    localparam logic [ROOT_W-1:0]  HUNDRED = 17'd100;

    localparam logic signed [ANG_W-1:0] ANG_180 = 28'sd11796480;
    localparam logic signed [ANG_W-1:0] ANG_360 = 28'sd23592960;
    localparam logic signed [ANG_W-1:0] ANG_540 = 28'sd35389440;
    localparam logic signed [ANG_W-1:0] ANG_720 = 28'sd47185920;
    localparam logic signed [ANG_W-1:0] ANG_900 = 28'sd58982400;
    localparam logic signed [ANG_W-1:0] ANG_ONE_M1 = 28'sd65535;

    // Pipeline stage positions.
    localparam int ST_SQ      = 1;
    localparam int ST_CORDIC0 = 2;
    localparam int ST_SQRT0   = 3;
    localparam int ST_RECIP   = 20;
    localparam int ST_ROUND   = 21;
    localparam int ST_CRS     = 22;
    localparam int ST_WRAP    = 23;
    localparam int ST_TRUNC   = 24;
    localparam int NS         = 25;

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_NAV = 2'd0;
    localparam logic [1:0] REG_BX  = 2'd1;
    localparam logic [1:0] REG_BY  = 2'd2;
    localparam logic [1:0] REG_BZ  = 2'd3;

    typedef struct packed {
        logic                     en;
        logic [HEAD_W-1:0]        head;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] alt_raw;
        logic signed [ALT_W-1:0]  alt;
        logic [SQ_W-1:0]          sqx;
        logic [SQ_W-1:0]          sqy;
        logic [REM_W-1:0]         rem;
        logic [ROOT_W-1:0]        root;
        logic [PROD_W-1:0]        prod;
        logic [ROOT_W-1:0]        dist_val;
        logic signed [CX_W-1:0]   cx;
        logic signed [CX_W-1:0]   cy;
        logic signed [ANG_W-1:0]  cz;
        logic                     zero;
        logic signed [ANG_W-1:0]  crs;
        logic signed [ANG_W-1:0]  w;
        logic signed [RB_W-1:0]   rb;
    } stage_t;

    // atan(2^-i) in units of 2^-16 degree.
    function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
        logic signed [ANG_W-1:0] a;
        case (i)
            0:  a = 28'sd2949120;
            1:  a = 28'sd1740967;
            2:  a = 28'sd919879;
            3:  a = 28'sd466945;
            4:  a = 28'sd234379;
            5:  a = 28'sd117304;
            6:  a = 28'sd58666;
            7:  a = 28'sd29335;
            8:  a = 28'sd14668;
            9:  a = 28'sd7334;
            10: a = 28'sd3667;
            11: a = 28'sd1833;
            12: a = 28'sd917;
            13: a = 28'sd458;
            14: a = 28'sd229;
            15: a = 28'sd115;
            16: a = 28'sd57;
            17: a = 28'sd29;
            18: a = 28'sd14;
            19: a = 28'sd7;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ----- src/beacon_range_bearing.sv -----
// Top level of the beacon range and bearing block: APB registers and the full pipeline.
// Depends on brb_pkg.
`default_nettype none

// Usage
// The block takes one vehicle item (pos_x, pos_y, pos_z, heading) on the in_valid /
// in_ready channel and returns one result item (valid_res, distance, altitude_diff,
// rel_bearing) on the out_valid / out_ready channel for every item taken.
// The user must write the beacon position and the nav_enabled flag over the APB port
// only while no item is in flight; the block does not enforce this. pready is always
// high and reads return the stored values. One item can be taken every cycle while
// the output is not stalled: the pipeline has 25 register stages, set mainly by the
// 20 CORDIC iterations for the bearing, which overlap a 17-step square root for the
// range. When the receiver holds out_ready low with a result waiting, the whole
// pipeline holds and in_ready falls; no item is lost or repeated. A bubble in the
// final stage lets the pipeline move even while out_ready is low.
// Reset clears the configuration registers and the stage valid bits, which empties
// the pipeline; the stage data registers are not reset.
// With nav_enabled at zero each result item carries valid_res = 0 and zero fields.
module beacon_range_bearing
    import brb_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ADDR_W-1:0]         paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [COORD_W-1:0] pos_x,
    input  wire logic signed [COORD_W-1:0] pos_y,
    input  wire logic signed [COORD_W-1:0] pos_z,
    input  wire logic [HEAD_W-1:0]         heading,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           valid_res,
    output logic [ROOT_W-1:0]              distance,
    output logic signed [ALT_W-1:0]        altitude_diff,
    output logic signed [RB_W-1:0]         rel_bearing
);

    logic               nav_reg;
    logic [COORD_W-1:0] bx_reg;
    logic [COORD_W-1:0] by_reg;
    logic [COORD_W-1:0] bz_reg;
    logic               wr_en;
    logic               advance;
    logic [NS-1:0]      vld_reg;
    stage_t             pipe_reg  [NS];
    stage_t             pipe_next [NS];

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nav_reg <= 1'b0;
            bx_reg  <= '0;
            by_reg  <= '0;
            bz_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_NAV: nav_reg <= pwdata[0];
                REG_BX:  bx_reg  <= pwdata[COORD_W-1:0];
                REG_BY:  by_reg  <= pwdata[COORD_W-1:0];
                REG_BZ:  bz_reg  <= pwdata[COORD_W-1:0];
                default: nav_reg <= nav_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_NAV: prdata = {31'b0, nav_reg};
            REG_BX:  prdata = {{(32-COORD_W){1'b0}}, bx_reg};
            REG_BY:  prdata = {{(32-COORD_W){1'b0}}, by_reg};
            REG_BZ:  prdata = {{(32-COORD_W){1'b0}}, bz_reg};
            default: prdata = '0;
        endcase
    end

    // The pipeline moves as one unit unless a finished result is stuck at the output.
    assign advance  = !vld_reg[NS-1] || out_ready;
    assign in_ready = advance;

    // Stage 0: differences to the beacon.
    always_comb
    begin
        pipe_next[0]         = '0;
        pipe_next[0].en      = nav_reg;
        pipe_next[0].head    = heading;
        pipe_next[0].dx      = {pos_x[COORD_W-1], pos_x} - {bx_reg[COORD_W-1], bx_reg};
        pipe_next[0].dy      = {by_reg[COORD_W-1], by_reg} - {pos_y[COORD_W-1], pos_y};
        pipe_next[0].alt_raw = {pos_z[COORD_W-1], pos_z} - {bz_reg[COORD_W-1], bz_reg};
    end

    for (genvar s = 1; s < NS; s++)
    begin : g_stage
        localparam int CI = (s >= ST_CORDIC0 && s < ST_CORDIC0 + CORDIC_N) ?
                            s - ST_CORDIC0 : 0;
        localparam int SK = (s >= ST_SQRT0 && s < ST_SQRT0 + ROOT_W) ?
                            ROOT_W - 1 - (s - ST_SQRT0) : 0;

        always_comb
        begin
            stage_t                  p;
            stage_t                  n;
            logic [DIFF_W-1:0]       ax;
            logic [DIFF_W-1:0]       ay;
            logic signed [CX_W-1:0]  xs;
            logic signed [CX_W-1:0]  ys;
            logic [SQ_W-1:0]         sum;
            logic [REM_W-1:0]        trial;
            logic [QUOT_W-1:0]       quot;
            logic [ROOT_W-1:0]       hund;
            logic signed [ANG_W-1:0] azim;
            logic signed [ANG_W-1:0] hd;
            logic signed [DIFF_W-1:0] alt_adj;
            logic signed [ANG_W-1:0] w_adj;
            logic signed [ANG_W-1:0] w_sh;
            p = pipe_reg[s-1];
            n = p;
            ax = '0;
            ay = '0;
            xs = '0;
            ys = '0;
            sum = '0;
            trial = '0;
            quot = '0;
            hund = '0;
            azim = '0;
            hd = '0;
            alt_adj = '0;
            w_adj = '0;
            w_sh = '0;

            if (s == ST_SQ)
            begin
                ax    = p.dx[DIFF_W-1] ? DIFF_W'(-p.dx) : p.dx;
                ay    = p.dy[DIFF_W-1] ? DIFF_W'(-p.dy) : p.dy;
                n.sqx = ax * ax;
                n.sqy = ay * ay;
                n.zero = (p.dx == '0) && (p.dy == '0);
                n.cx  = {{(CX_W-DIFF_W){p.dy[DIFF_W-1]}}, p.dy} <<< PRESCALE_SH;
                n.cy  = {{(CX_W-DIFF_W){p.dx[DIFF_W-1]}}, p.dx} <<< PRESCALE_SH;
                n.cz  = '0;
                if (p.dy[DIFF_W-1])
                begin
                    n.cz = p.dx[DIFF_W-1] ? -ANG_180 : ANG_180;
                    n.cx = -n.cx;
                    n.cy = -n.cy;
                end
                alt_adj = p.alt_raw + (p.alt_raw[DIFF_W-1] ?
                          DIFF_W'((1 << FRAC_BITS) - 1) : DIFF_W'(0));
                n.alt = ALT_W'(alt_adj >>> FRAC_BITS);
            end

            if (s == ST_CORDIC0)
            begin
                sum    = p.sqx + p.sqy;
                n.rem  = REM_W'(sum >> (2 * FRAC_BITS));
                n.root = '0;
            end

            if (s >= ST_CORDIC0 && s < ST_CORDIC0 + CORDIC_N)
            begin
                xs = p.cx >>> CI;
                ys = p.cy >>> CI;
                if (!p.cy[CX_W-1])
                begin
                    n.cx = p.cx + ys;
                    n.cy = p.cy - xs;
                    n.cz = p.cz + atan_entry(CI);
                end
                else
                begin
                    n.cx = p.cx - ys;
                    n.cy = p.cy + xs;
                    n.cz = p.cz - atan_entry(CI);
                end
            end

            if (s >= ST_SQRT0 && s < ST_SQRT0 + ROOT_W)
            begin
                trial = (REM_W'(p.root) << (SK + 1)) + (REM_W'(1) << (2 * SK));
                if (p.rem >= trial)
                begin
                    n.rem  = p.rem - trial;
                    n.root = p.root | (ROOT_W'(1) << SK);
                end
            end

            if (s == ST_RECIP)
            begin
                n.prod = p.root * RECIP_100;
            end

            if (s == ST_ROUND)
            begin
                quot   = p.prod[PROD_W-1:RECIP_SH];
                hund   = ROOT_W'(quot) * HUNDRED;
                n.dist_val = (p.root > DIST_LIMIT) ? hund : p.root;
            end

            if (s == ST_CRS)
            begin
                azim  = p.zero ? ANG_W'(0) : p.cz;
                hd    = $signed({{(ANG_W-HEAD_W-HEAD_SH){1'b0}}, p.head, {HEAD_SH{1'b0}}});
                n.crs = ANG_360 - hd + azim + ANG_180;
            end

            if (s == ST_WRAP)
            begin
                if (p.crs < 0)
                    n.w = p.crs + ANG_180;
                else if (p.crs < ANG_360)
                    n.w = p.crs - ANG_180;
                else if (p.crs < ANG_720)
                    n.w = p.crs - ANG_540;
                else
                    n.w = p.crs - ANG_900;
            end

            if (s == ST_TRUNC)
            begin
                w_adj = p.w + (p.w[ANG_W-1] ? ANG_ONE_M1 : ANG_W'(0));
                w_sh  = w_adj >>> 16;
                n.rb  = w_sh[RB_W-1:0];
            end

            pipe_next[s] = n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[NS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            pipe_reg <= pipe_next;
    end

    assign out_valid     = vld_reg[NS-1];
    assign valid_res     = pipe_reg[NS-1].en;
    assign distance      = pipe_reg[NS-1].en ? pipe_reg[NS-1].dist_val : '0;
    assign altitude_diff = pipe_reg[NS-1].en ? pipe_reg[NS-1].alt : '0;
    assign rel_bearing   = pipe_reg[NS-1].en ? pipe_reg[NS-1].rb : '0;

endmodule

`default_nettype wire

// ----- src/brb_checker.sv -----
// Port-level checker for the beacon range and bearing block, bound to the top level.
// Depends on brb_pkg and beacon_range_bearing.
`default_nettype none

module brb_checker
    import brb_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_ready,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic                      valid_res,
    input wire logic [ROOT_W-1:0]         distance,
    input wire logic signed [ALT_W-1:0]   altitude_diff,
    input wire logic signed [RB_W-1:0]    rel_bearing
);

    // A result held by the receiver keeps its fields.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance) &&
        $stable(rel_bearing) && $stable(altitude_diff))
        else $error("stalled result changed");

    // Disabled navigation gives zero fields.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> distance == '0 && altitude_diff == '0 &&
        rel_bearing == '0)
        else $error("disabled result not zero");

    // Range never exceeds the largest possible horizontal distance.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> distance <= 17'd92700)
        else $error("distance out of range");

    // The input side waits only behind a stalled result.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled without cause");

endmodule

bind beacon_range_bearing brb_checker u_brb_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .valid_res(valid_res),
    .distance(distance),
    .altitude_diff(altitude_diff),
    .rel_bearing(rel_bearing)
);

`default_nettype wire
